@@ rtl/rsd_pkg.sv @@
package rsd_pkg;

   localparam int DEF_BLOCK_SIZE  = 512;
   localparam int DEF_BLOCK_COUNT = 191;
   localparam int DEF_SONG_BYTES  = 32768;

   // escape and command bytes
   localparam logic [7:0] ESC_RUN     = 8'hC0;
   localparam logic [7:0] ESC_SPECIAL = 8'hE0;
   localparam logic [7:0] CODE_WAVE   = 8'hF0;
   localparam logic [7:0] CODE_INSTR  = 8'hF1;
   localparam logic [7:0] CODE_END    = 8'hFF;

   // default 16-byte patterns, byte 0 in the low bits
   localparam logic [63:0] WAVE_LOW   = 64'h8899_A9AA_BBCC_CD8E;
   localparam logic [63:0] WAVE_HIGH  = 64'h3132_4354_5566_7687;
   localparam logic [63:0] INSTR_LOW  = 64'h0003_0000_FF00_00A8;
   localparam logic [63:0] INSTR_HIGH = 64'h0000_F300_0000_D000;

   // register index, taken from paddr bit 2
   localparam logic CSR_START_BLOCK = 1'b0;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_RUN_VALUE   = 3'd1,
      PH_RUN_COUNT   = 3'd2,
      PH_SPECIAL     = 3'd3,
      PH_WAVE_COUNT  = 3'd4,
      PH_INSTR_COUNT = 3'd5
   } rsd_phase_type;

   typedef enum logic [2:0] {
      KIND_LITERAL = 3'd0,
      KIND_RUN     = 3'd1,
      KIND_WAVE    = 3'd2,
      KIND_INSTR   = 3'd3,
      KIND_JUMP    = 3'd4,
      KIND_END     = 3'd5,
      KIND_ERROR   = 3'd6
   } rsd_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_OVERFLOW    = 3'd1,
      ERR_BAD_JUMP    = 3'd2,
      ERR_FINAL_SIZE  = 3'd3,
      ERR_MANY_BLOCKS = 3'd4,
      ERR_READ_PAST   = 3'd5
   } rsd_err_type;

   typedef struct packed {
      logic       wr;
      logic [7:0] wdata;
      logic [7:0] start_block;
   } rsd_csr_type;

   typedef struct packed {
      rsd_kind_type kind;
      logic [63:0]  pattern_low;
      logic [63:0]  pattern_high;
      logic [4:0]   pattern_length;
      logic [7:0]   repeat_count;
      logic [15:0]  bytes_written;
      logic [16:0]  next_fetch_address;
      rsd_err_type  error_code;
   } rsd_result_type;

endpackage

@@ rtl/rsd_csr.sv @@
module rsd_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output rsd_pkg::rsd_csr_type csr
);

   logic [7:0] start_block_ff;
   logic [7:0] start_block_in;
   logic       wr;
   logic       sel_start;

   assign sel_start = (csr_paddr[2] == rsd_pkg::CSR_START_BLOCK);
   assign wr        = csr_psel && csr_penable && csr_pwrite && sel_start;

   assign start_block_in = wr ? csr_pwdata[7:0] : start_block_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_block_ff <= 8'd0;
      end else begin
         start_block_ff <= start_block_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = sel_start ? {24'd0, start_block_ff} : 32'd0;

   assign csr.wr          = wr;
   assign csr.wdata       = csr_pwdata[7:0];
   assign csr.start_block = start_block_ff;

endmodule

@@ rtl/rsd_parser.sv @@
module rsd_parser #(
   parameter int BLOCK_SIZE  = rsd_pkg::DEF_BLOCK_SIZE,
   parameter int BLOCK_COUNT = rsd_pkg::DEF_BLOCK_COUNT,
   parameter int SONG_BYTES  = rsd_pkg::DEF_SONG_BYTES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_fire,
   input  logic [7:0]              comp_byte,
   input  rsd_pkg::rsd_csr_type    csr,
   output logic                    res_valid,
   output rsd_pkg::rsd_result_type res
);

   localparam int ADDR_W = $clog2(256 * BLOCK_SIZE);
   localparam int WIDE_W = ADDR_W + 17;
   localparam logic [ADDR_W-1:0] ADDR_LIMIT = ADDR_W'(BLOCK_COUNT * BLOCK_SIZE);
   localparam logic [ADDR_W-1:0] BLOCK_BYTES = ADDR_W'(BLOCK_SIZE);
   localparam logic [16:0] SONG_SUM   = 17'(SONG_BYTES);
   localparam logic [15:0] SONG_TOTAL = 16'(SONG_BYTES);
   localparam logic [7:0]  BLOCK_MAX  = 8'(BLOCK_COUNT);

   rsd_pkg::rsd_phase_type phase_ff, phase_in;
   logic [7:0]        held_ff, held_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [15:0]       total_ff, total_in;
   logic [7:0]        blocks_ff, blocks_in;

   logic [ADDR_W-1:0] start_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] jump_addr;
   logic [ADDR_W-1:0] fetch_addr;
   logic [WIDE_W-1:0] fetch_wide;

   logic                  fail;
   rsd_pkg::rsd_err_type  fail_code;
   logic                  end_en;
   logic                  jump_en;
   logic                  go_idle;
   logic                  data_en;
   rsd_pkg::rsd_kind_type data_kind;
   logic [63:0]           data_lo;
   logic [63:0]           data_hi;
   logic                  data_wide;
   logic [7:0]            data_rep;
   logic [16:0]           sum;

   assign start_addr = ADDR_W'(csr.start_block) * BLOCK_BYTES;
   assign wr_addr    = ADDR_W'(csr.wdata) * BLOCK_BYTES;
   assign jump_addr  = ADDR_W'(comp_byte - 8'd1) * BLOCK_BYTES;

   // command decode
   always_comb begin
      fail      = 1'b0;
      fail_code = rsd_pkg::ERR_NONE;
      end_en    = 1'b0;
      jump_en   = 1'b0;
      go_idle   = 1'b0;
      data_en   = 1'b0;
      data_kind = rsd_pkg::KIND_LITERAL;
      data_lo   = {56'd0, comp_byte};
      data_hi   = 64'd0;
      data_wide = 1'b0;
      data_rep  = 8'd1;
      phase_in  = phase_ff;
      held_in   = held_ff;
      addr_in   = addr_ff;
      if (in_fire) begin
         if (addr_ff >= ADDR_LIMIT) begin
            fail      = 1'b1;
            fail_code = rsd_pkg::ERR_READ_PAST;
         end else begin
            addr_in = addr_ff + 1'b1;
            unique case (phase_ff)
               rsd_pkg::PH_IDLE: begin
                  if (comp_byte == rsd_pkg::ESC_RUN) begin
                     phase_in = rsd_pkg::PH_RUN_VALUE;
                  end else if (comp_byte == rsd_pkg::ESC_SPECIAL) begin
                     phase_in = rsd_pkg::PH_SPECIAL;
                  end else begin
                     data_en = 1'b1;
                  end
               end
               rsd_pkg::PH_RUN_VALUE: begin
                  if (comp_byte == rsd_pkg::ESC_RUN) begin
                     data_en = 1'b1;
                  end else begin
                     held_in  = comp_byte;
                     phase_in = rsd_pkg::PH_RUN_COUNT;
                  end
               end
               rsd_pkg::PH_RUN_COUNT: begin
                  data_en   = 1'b1;
                  data_kind = rsd_pkg::KIND_RUN;
                  data_lo   = {56'd0, held_ff};
                  data_rep  = comp_byte;
               end
               rsd_pkg::PH_SPECIAL: begin
                  priority if (comp_byte == rsd_pkg::ESC_SPECIAL) begin
                     data_en = 1'b1;
                  end else if (comp_byte == rsd_pkg::CODE_WAVE) begin
                     phase_in = rsd_pkg::PH_WAVE_COUNT;
                  end else if (comp_byte == rsd_pkg::CODE_INSTR) begin
                     phase_in = rsd_pkg::PH_INSTR_COUNT;
                  end else if (comp_byte == rsd_pkg::CODE_END) begin
                     if (total_ff != SONG_TOTAL) begin
                        fail      = 1'b1;
                        fail_code = rsd_pkg::ERR_FINAL_SIZE;
                     end else begin
                        end_en = 1'b1;
                     end
                  end else if (comp_byte == 8'd0 || comp_byte > BLOCK_MAX) begin
                     fail      = 1'b1;
                     fail_code = rsd_pkg::ERR_BAD_JUMP;
                  end else if (blocks_ff >= BLOCK_MAX) begin
                     fail      = 1'b1;
                     fail_code = rsd_pkg::ERR_MANY_BLOCKS;
                  end else begin
                     jump_en = 1'b1;
                  end
               end
               rsd_pkg::PH_WAVE_COUNT: begin
                  data_en   = 1'b1;
                  data_kind = rsd_pkg::KIND_WAVE;
                  data_lo   = rsd_pkg::WAVE_LOW;
                  data_hi   = rsd_pkg::WAVE_HIGH;
                  data_wide = 1'b1;
                  data_rep  = comp_byte;
               end
               rsd_pkg::PH_INSTR_COUNT: begin
                  data_en   = 1'b1;
                  data_kind = rsd_pkg::KIND_INSTR;
                  data_lo   = rsd_pkg::INSTR_LOW;
                  data_hi   = rsd_pkg::INSTR_HIGH;
                  data_wide = 1'b1;
                  data_rep  = comp_byte;
               end
               default: begin
                  go_idle = 1'b1;
               end
            endcase
         end
      end
   end

   // new total: old total plus pattern length times repeat count
   assign sum = {1'b0, total_ff}
              + (data_wide ? {5'd0, data_rep, 4'd0} : {9'd0, data_rep});

   // result and state update
   always_comb begin
      res_valid  = 1'b0;
      res        = '0;
      total_in   = total_ff;
      blocks_in  = blocks_ff;
      fetch_addr = addr_in;
      if (data_en) begin
         if (sum > SONG_SUM) begin
            res_valid            = 1'b1;
            res.kind             = rsd_pkg::KIND_ERROR;
            res.error_code       = rsd_pkg::ERR_OVERFLOW;
            res.bytes_written    = SONG_TOTAL;
            fetch_addr           = start_addr;
         end else begin
            res_valid            = 1'b1;
            res.kind             = data_kind;
            res.pattern_low      = data_lo;
            res.pattern_high     = data_hi;
            res.pattern_length   = data_wide ? 5'd16 : 5'd1;
            res.repeat_count     = data_rep;
            res.bytes_written    = sum[15:0];
            total_in             = sum[15:0];
         end
      end else if (fail) begin
         res_valid         = 1'b1;
         res.kind          = rsd_pkg::KIND_ERROR;
         res.error_code    = fail_code;
         res.bytes_written = total_ff;
         fetch_addr        = start_addr;
      end else if (end_en) begin
         res_valid         = 1'b1;
         res.kind          = rsd_pkg::KIND_END;
         res.bytes_written = SONG_TOTAL;
         fetch_addr        = start_addr;
      end else if (jump_en) begin
         res_valid         = 1'b1;
         res.kind          = rsd_pkg::KIND_JUMP;
         res.bytes_written = total_ff;
         blocks_in         = blocks_ff + 8'd1;
         fetch_addr        = jump_addr;
      end
      fetch_wide = WIDE_W'(fetch_addr);
      res.next_fetch_address = fetch_wide[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rsd_pkg::PH_IDLE;
         held_ff   <= 8'd0;
         addr_ff   <= '0;
         total_ff  <= 16'd0;
         blocks_ff <= 8'd0;
      end else if (csr.wr) begin
         // register write restarts at the new start block
         phase_ff  <= rsd_pkg::PH_IDLE;
         held_ff   <= 8'd0;
         addr_ff   <= wr_addr;
         total_ff  <= 16'd0;
         blocks_ff <= 8'd0;
      end else if (go_idle || fail || end_en || (data_en && sum > SONG_SUM)) begin
         phase_ff  <= rsd_pkg::PH_IDLE;
         held_ff   <= 8'd0;
         addr_ff   <= start_addr;
         total_ff  <= 16'd0;
         blocks_ff <= 8'd0;
      end else begin
         phase_ff  <= (data_en || jump_en) ? rsd_pkg::PH_IDLE : phase_in;
         held_ff   <= held_in;
         addr_ff   <= jump_en ? jump_addr : addr_in;
         total_ff  <= total_in;
         blocks_ff <= blocks_in;
      end
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= SONG_TOTAL)
      else $error("decoded total above song size");

   a_blocks_bound: assert property (@(posedge clock) disable iff (reset)
      blocks_ff <= BLOCK_MAX)
      else $error("jump count above block count");

   a_error_restarts: assert property (@(posedge clock) disable iff (reset)
      (in_fire && res_valid && res.kind == rsd_pkg::KIND_ERROR)
      |=> (phase_ff == rsd_pkg::PH_IDLE && total_ff == 16'd0 && blocks_ff == 8'd0))
      else $error("decoder not back in idle after an error");

   a_mid_command_silent: assert property (@(posedge clock) disable iff (reset)
      (in_fire && (phase_in == rsd_pkg::PH_RUN_VALUE || phase_in == rsd_pkg::PH_SPECIAL
                   || phase_in == rsd_pkg::PH_RUN_COUNT)
       && phase_in != phase_ff) |-> !res_valid)
      else $error("result raised on a mid-command byte");

endmodule

@@ rtl/rsd_out_reg.sv @@
module rsd_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_fire,
   input  logic                    res_valid,
   input  rsd_pkg::rsd_result_type res,
   input  logic                    out_ready,
   output logic                    out_valid,
   output rsd_pkg::rsd_result_type out_data,
   output logic                    in_ready
);

   logic                    valid_ff, valid_in;
   rsd_pkg::rsd_result_type data_ff, data_in;
   logic                    load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_fire && res_valid;

   assign valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   assign data_in  = load ? res : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/block_rle_song_decompressor.sv @@
// Escape-byte run-length song decoder.
// req channel: one compressed byte per transfer, fetched by the user from
// the address last shown in next_fetch_address (start_block * BLOCK_SIZE
// after reset, after a start_block write and after each end or error).
// rsp channel: at most one segment per byte: a literal, a 1-byte run, a
// 16-byte wave or instrument run, a block jump, an end or an error; the
// writer downstream expands the pattern repeat_count times.
// Bytes inside a command (escape, run value) produce no transfer on rsp.
// A segment appears on rsp in the cycle after its last byte is taken.
// Throughput: one byte per cycle; the parse state updates in the same cycle
// the byte is taken and the segment lands in a single result register.
// If the receiver stalls with a segment held, req_tready drops until it is
// taken; bytes are taken again in the cycle rsp_tready returns.
// Reset (synchronous) clears start_block to 0 and the decoder to idle.
// csr port: register 0 (start_block) at byte address 0; a write aborts any
// decode in progress and restarts at the new block.
module block_rle_song_decompressor #(
   parameter int BLOCK_SIZE  = rsd_pkg::DEF_BLOCK_SIZE,
   parameter int BLOCK_COUNT = rsd_pkg::DEF_BLOCK_COUNT,
   parameter int SONG_BYTES  = rsd_pkg::DEF_SONG_BYTES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // comp_byte
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // pattern_low, pattern_high, pattern_length, repeat_count,
   // bytes_written, next_fetch_address, error_code, zero fill
   output logic [183:0]  rsp_tdata,
   output logic [2:0]    rsp_tuser,   // segment_kind
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   rsd_pkg::rsd_csr_type    csr;
   rsd_pkg::rsd_result_type res;
   rsd_pkg::rsd_result_type out_data;
   logic                    res_valid;
   logic                    in_fire;

   assign in_fire = req_tvalid && req_tready;

   rsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .csr         (csr)
   );

   rsd_parser #(
      .BLOCK_SIZE  (BLOCK_SIZE),
      .BLOCK_COUNT (BLOCK_COUNT),
      .SONG_BYTES  (SONG_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .comp_byte (req_tdata),
      .csr       (csr),
      .res_valid (res_valid),
      .res       (res)
   );

   rsd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .res_valid (res_valid),
      .res       (res),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .in_ready  (req_tready)
   );

   assign rsp_tuser = out_data.kind;
   assign rsp_tdata = {7'd0,
                       out_data.error_code,
                       out_data.next_fetch_address,
                       out_data.bytes_written,
                       out_data.repeat_count,
                       out_data.pattern_length,
                       out_data.pattern_high,
                       out_data.pattern_low};

endmodule

@@ tb/sv/block_rle_song_decompressor_tb.sv @@
`timescale 1ns / 1ps

module block_rle_song_decompressor_tb;
   import rsd_pkg::*;

   localparam int BLK_SIZE       = DEF_BLOCK_SIZE;
   localparam int BLK_COUNT      = DEF_BLOCK_COUNT;
   localparam int SONG_TOTAL     = DEF_SONG_BYTES;
   localparam int AREA_END       = BLK_COUNT * BLK_SIZE;
   localparam int PHASE_ITEMS    = 110;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 8;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int MAX_PRINTED    = 40;

   // default 16-byte patterns, byte 0 in the low bits
   localparam logic [63:0] WAVE_BYTES_LO  = 64'h8899_A9AA_BBCC_CD8E;
   localparam logic [63:0] WAVE_BYTES_HI  = 64'h3132_4354_5566_7687;
   localparam logic [63:0] INSTR_BYTES_LO = 64'h0003_0000_FF00_00A8;
   localparam logic [63:0] INSTR_BYTES_HI = 64'h0000_F300_0000_D000;

   typedef struct {
      logic [7:0]   b;
      bit           typed;
      rsd_kind_type kind;
      rsd_err_type  err;
   } row_type;

   typedef struct {
      rsd_result_type seg;
      bit             typed;
      rsd_kind_type   typed_kind;
      rsd_err_type    typed_err;
   } pending_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [7:0]    req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [183:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [2:0]    csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   // decoder state as the predictor sees it
   logic [7:0]    cfg_start;
   rsd_phase_type ph;
   logic [7:0]    held;
   int unsigned   rd_addr;
   int unsigned   total;
   int unsigned   jumps;

   pending_type   pending_segs[$];
   pending_type   pend_entry;
   rsd_result_type next_seg;
   row_type       cur_row;

   int            gap_pct = 0;
   int            stall_pct = 0;
   int            hold_left = 0;
   int            cycle_count = 0;
   int            n_taken = 0;
   int            n_segs = 0;
   int            n_end_ok = 0;
   int            n_errors = 0;
   int            n_fail = 0;
   int            phase_end;

   row_type directed_bytes [25] = '{
      '{8'h00,       1'b1, KIND_LITERAL, ERR_NONE},
      '{ESC_RUN,     1'b0, KIND_LITERAL, ERR_NONE},
      '{ESC_RUN,     1'b1, KIND_LITERAL, ERR_NONE},
      '{ESC_SPECIAL, 1'b0, KIND_LITERAL, ERR_NONE},
      '{ESC_SPECIAL, 1'b1, KIND_LITERAL, ERR_NONE},
      '{ESC_RUN,     1'b0, KIND_LITERAL, ERR_NONE},
      '{8'h55,       1'b0, KIND_LITERAL, ERR_NONE},
      '{8'h00,       1'b1, KIND_RUN,     ERR_NONE},
      '{ESC_RUN,     1'b0, KIND_LITERAL, ERR_NONE},
      '{8'hFF,       1'b0, KIND_LITERAL, ERR_NONE},
      '{8'hFF,       1'b1, KIND_RUN,     ERR_NONE},
      '{ESC_SPECIAL, 1'b0, KIND_LITERAL, ERR_NONE},
      '{CODE_WAVE,   1'b0, KIND_LITERAL, ERR_NONE},
      '{8'hFF,       1'b1, KIND_WAVE,    ERR_NONE},
      '{ESC_SPECIAL, 1'b0, KIND_LITERAL, ERR_NONE},
      '{CODE_INSTR,  1'b0, KIND_LITERAL, ERR_NONE},
      '{8'h00,       1'b1, KIND_INSTR,   ERR_NONE},
      '{ESC_SPECIAL, 1'b0, KIND_LITERAL, ERR_NONE},
      '{8'd191,      1'b1, KIND_JUMP,    ERR_NONE},
      '{ESC_SPECIAL, 1'b0, KIND_LITERAL, ERR_NONE},
      '{8'd0,        1'b1, KIND_ERROR,   ERR_BAD_JUMP},
      '{ESC_SPECIAL, 1'b0, KIND_LITERAL, ERR_NONE},
      '{8'd192,      1'b1, KIND_ERROR,   ERR_BAD_JUMP},
      '{ESC_SPECIAL, 1'b0, KIND_LITERAL, ERR_NONE},
      '{CODE_END,    1'b1, KIND_ERROR,   ERR_FINAL_SIZE}
   };

   block_rle_song_decompressor u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // ---------------- predictor ----------------

   function automatic void restart();
      ph = PH_IDLE;
      held = '0;
      rd_addr = int'(cfg_start) * BLK_SIZE;
      total = 0;
      jumps = 0;
   endfunction

   function automatic rsd_result_type make_seg(input rsd_kind_type k, input logic [63:0] lo,
         input logic [63:0] hi, input int unsigned len, input int unsigned rep,
         input rsd_err_type e, input int unsigned tot);
      rsd_result_type r;
      r.kind = k;
      r.pattern_low = lo;
      r.pattern_high = hi;
      r.pattern_length = 5'(len);
      r.repeat_count = 8'(rep);
      r.bytes_written = 16'((tot > SONG_TOTAL) ? SONG_TOTAL : tot);
      r.next_fetch_address = 17'(rd_addr);
      r.error_code = e;
      return r;
   endfunction

   // error segment: reports the total reached, then the decoder restarts
   function automatic rsd_result_type fault(input rsd_err_type e);
      int unsigned tot;
      tot = total;
      restart();
      return make_seg(KIND_ERROR, '0, '0, 0, 0, e, tot);
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, output rsd_result_type seg);
      rsd_kind_type k;
      logic [63:0]  lo;
      logic [63:0]  hi;
      int unsigned  len;
      int unsigned  rep;
      k = KIND_LITERAL;
      lo = 64'(b);
      hi = '0;
      len = 1;
      rep = 1;
      seg = '0;
      if (rd_addr >= AREA_END) begin
         seg = fault(ERR_READ_PAST);
         return 1'b1;
      end
      rd_addr++;
      case (ph)
         PH_IDLE: begin
            if (b == ESC_RUN || b == ESC_SPECIAL) begin
               ph = (b == ESC_RUN) ? PH_RUN_VALUE : PH_SPECIAL;
               return 1'b0;
            end
         end
         PH_RUN_VALUE: begin
            if (b != ESC_RUN) begin
               held = b;
               ph = PH_RUN_COUNT;
               return 1'b0;
            end
         end
         PH_RUN_COUNT: begin
            k = KIND_RUN;
            lo = 64'(held);
            rep = b;
         end
         PH_SPECIAL: begin
            if (b == CODE_WAVE || b == CODE_INSTR) begin
               ph = (b == CODE_WAVE) ? PH_WAVE_COUNT : PH_INSTR_COUNT;
               return 1'b0;
            end
            if (b == CODE_END) begin
               if (total != SONG_TOTAL) begin
                  seg = fault(ERR_FINAL_SIZE);
                  return 1'b1;
               end
               restart();
               seg = make_seg(KIND_END, '0, '0, 0, 0, ERR_NONE, SONG_TOTAL);
               return 1'b1;
            end
            if (b != ESC_SPECIAL) begin
               if (b == 8'd0 || int'(b) > BLK_COUNT) begin
                  seg = fault(ERR_BAD_JUMP);
                  return 1'b1;
               end
               if (jumps >= BLK_COUNT) begin
                  seg = fault(ERR_MANY_BLOCKS);
                  return 1'b1;
               end
               jumps++;
               ph = PH_IDLE;
               rd_addr = (int'(b) - 1) * BLK_SIZE;
               seg = make_seg(KIND_JUMP, '0, '0, 0, 0, ERR_NONE, total);
               return 1'b1;
            end
         end
         PH_WAVE_COUNT: begin
            k = KIND_WAVE;
            lo = WAVE_BYTES_LO;
            hi = WAVE_BYTES_HI;
            len = 16;
            rep = b;
         end
         PH_INSTR_COUNT: begin
            k = KIND_INSTR;
            lo = INSTR_BYTES_LO;
            hi = INSTR_BYTES_HI;
            len = 16;
            rep = b;
         end
         default: begin
            restart();
            return 1'b0;
         end
      endcase
      // plain or escaped literal, or a counted run
      ph = PH_IDLE;
      total += len * rep;
      if (total > SONG_TOTAL)
         seg = fault(ERR_OVERFLOW);
      else
         seg = make_seg(k, lo, hi, len, rep, ERR_NONE, total);
      return 1'b1;
   endfunction

   // ---------------- checking ----------------

   task automatic report_mismatch(input string msg);
      n_fail++;
      if (n_fail <= MAX_PRINTED)
         $display("mismatch at %0t, segment %0d: %s", $time, n_segs, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
         input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task automatic check_segment();
      rsd_result_type got;
      pending_type    want;
      got.kind = rsd_kind_type'(rsp_tuser);
      got.pattern_low = rsp_tdata[63:0];
      got.pattern_high = rsp_tdata[127:64];
      got.pattern_length = rsp_tdata[132:128];
      got.repeat_count = rsp_tdata[140:133];
      got.bytes_written = rsp_tdata[156:141];
      got.next_fetch_address = rsp_tdata[173:157];
      got.error_code = rsd_err_type'(rsp_tdata[176:174]);
      if (pending_segs.size() == 0) begin
         report_mismatch($sformatf("kind %0d arrived with nothing pending", rsp_tuser));
         return;
      end
      want = pending_segs.pop_front();
      n_segs++;
      if (want.seg.kind == KIND_END)
         n_end_ok++;
      if (want.seg.kind == KIND_ERROR)
         n_errors++;
      check_field("segment_kind", got.kind, want.seg.kind);
      check_field("pattern_low", got.pattern_low, want.seg.pattern_low);
      check_field("pattern_high", got.pattern_high, want.seg.pattern_high);
      check_field("pattern_length", got.pattern_length, want.seg.pattern_length);
      check_field("repeat_count", got.repeat_count, want.seg.repeat_count);
      check_field("bytes_written", got.bytes_written, want.seg.bytes_written);
      check_field("next_fetch_address", got.next_fetch_address,
                  want.seg.next_fetch_address);
      check_field("error_code", got.error_code, want.seg.error_code);
      check_field("zero fill", rsp_tdata[183:177], '0);
      if (want.typed) begin
         check_field("listed kind", got.kind, want.typed_kind);
         check_field("listed error", got.error_code, want.typed_err);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            check_segment();
         if (req_tvalid && req_tready) begin
            n_taken++;
            if (decode_byte(req_tdata, next_seg)) begin
               pend_entry = '{next_seg, cur_row.typed, cur_row.kind, cur_row.err};
               pending_segs.insert(pending_segs.size(), pend_entry);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            cfg_start = csr_pwdata[7:0];
            restart();
         end
      end
   end

   // ---------------- receiver side ----------------

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   // valid is left high after a transfer so back-to-back bytes need no toggle
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_segs.size() != 0)
         @(negedge clock);
      // escape bytes leave nothing pending, so give the block a few more cycles
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [7:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {CSR_START_BLOCK, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [7:0] want);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_paddr <= {CSR_START_BLOCK, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {24'd0, want})
         report_mismatch($sformatf("start_block read %0h expected %0h", csr_prdata, want));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_start_block(input logic [7:0] value);
      drain();
      csr_write(value);
      csr_read_check(value);
   endtask

   // finish whatever command is open, so the next sequence starts clean
   task automatic return_to_idle();
      while (ph != PH_IDLE)
         send_byte(8'h01);
   endtask

   function automatic logic [7:0] pick_count();
      return ($urandom_range(9) < 7) ? 8'($urandom_range(255, 200)) : 8'($urandom_range(255));
   endfunction

   // a well-formed song whose decoded size lands exactly on the song size
   task automatic send_song();
      int unsigned left;
      int unsigned k;
      return_to_idle();
      left = SONG_TOTAL - total;
      while (left >= 16 * 255) begin
         k = $urandom_range(255, 128);
         send_byte(ESC_SPECIAL);
         send_byte($urandom_range(1) ? CODE_WAVE : CODE_INSTR);
         send_byte(8'(k));
         left -= 16 * k;
         if ($urandom_range(9) == 0) begin
            send_byte(ESC_SPECIAL);
            send_byte(8'($urandom_range(150, 1)));
         end
      end
      if (left >= 16) begin
         k = left / 16;
         send_byte(ESC_SPECIAL);
         send_byte(CODE_WAVE);
         send_byte(8'(k));
         left -= 16 * k;
      end
      if (left != 0) begin
         send_byte(ESC_RUN);
         send_byte(8'($urandom_range(191)));
         send_byte(8'(left));
      end
      send_byte(ESC_SPECIAL);
      send_byte(CODE_END);
   endtask

   task automatic send_command();
      int unsigned pick;
      logic [7:0]  v;
      pick = $urandom_range(99);
      v = 8'($urandom);
      if (pick < 8) begin
         send_byte(v);
      end else if (pick < 22) begin
         send_byte((v == ESC_RUN || v == ESC_SPECIAL) ? v ^ 8'h01 : v);
      end else if (pick < 36) begin
         send_byte(ESC_RUN);
         send_byte((v == ESC_RUN) ? 8'h00 : v);
         send_byte(8'($urandom));
      end else if (pick < 40) begin
         send_byte(ESC_RUN);
         send_byte(ESC_RUN);
      end else if (pick < 44) begin
         send_byte(ESC_SPECIAL);
         send_byte(ESC_SPECIAL);
      end else if (pick < 56) begin
         send_byte(ESC_SPECIAL);
         send_byte(CODE_WAVE);
         send_byte(pick_count());
      end else if (pick < 66) begin
         send_byte(ESC_SPECIAL);
         send_byte(CODE_INSTR);
         send_byte(pick_count());
      end else if (pick < 80) begin
         send_byte(ESC_SPECIAL);
         send_byte(($urandom_range(9) < 8) ? 8'($urandom_range(BLK_COUNT, 1)) : v);
      end else if (pick < 83) begin
         send_byte(ESC_SPECIAL);
         send_byte(CODE_END);
      end else if (pick < 88) begin
         // lone escape: the next command gets swallowed as its operand
         send_byte($urandom_range(1) ? ESC_RUN : ESC_SPECIAL);
      end else if (pick < 92) begin
         return_to_idle();
         repeat (9) begin
            send_byte(ESC_SPECIAL);
            send_byte(CODE_WAVE);
            send_byte(8'hFF);
         end
      end else if (pick < 96) begin
         send_song();
      end else begin
         send_byte(ESC_SPECIAL);
         send_byte(v);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_start = '0;
      restart();
      cur_row = '{8'h00, 1'b0, KIND_LITERAL, ERR_NONE};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_read_check(8'd0);

      foreach (directed_bytes[i]) begin
         cur_row = directed_bytes[i];
         send_byte(directed_bytes[i].b);
      end
      cur_row.typed = 1'b0;
      send_song();

      // long receiver hold while literals keep coming, so the input backs up
      hold_left = HOLD_CYCLES;
      repeat (40) send_byte(8'($urandom_range(191, 1)));

      // start in the last block, then at and beyond the end of the area
      set_start_block(8'd190);
      repeat (6) send_byte(8'($urandom_range(191)));
      set_start_block(8'd255);
      repeat (4) send_byte(8'($urandom));
      set_start_block(8'd191);
      repeat (3) send_byte(8'($urandom));

      for (int p = 0; p < 4; p++) begin
         gap_pct = (p == 1) ? 71 : (p == 3) ? 27 : 0;
         stall_pct = (p == 2) ? 71 : (p == 3) ? 27 : 0;
         set_start_block((p == 0) ? 8'd0 : 8'($urandom_range(189, 1)));
         if (p == 0) begin
            // one jump more than the area holds blocks
            repeat (BLK_COUNT + 1) begin
               send_byte(ESC_SPECIAL);
               send_byte(8'($urandom_range(BLK_COUNT, 1)));
            end
         end
         phase_end = n_taken + PHASE_ITEMS;
         while (n_taken < phase_end)
            send_command();
      end

      drain();
      if (pending_segs.size() != 0)
         report_mismatch($sformatf("%0d segments never arrived", pending_segs.size()));
      $display("%0d compressed bytes taken, %0d segments checked, %0d end marks, %0d errors",
               n_taken, n_segs, n_end_ok, n_errors);
      $display("start blocks 0, 190, 191, 255 and random; gaps and stalls up to 71 percent");
      if (n_fail == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
